### hdl/kmp_pkg.sv
// ----------------------------------------------------------------------------
// kmp_pkg
// shared types, widths and codes of the streaming kmp pattern matcher
// ----------------------------------------------------------------------------
package kmp_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int IDX_W       = $clog2(PATTERN_MAX);
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 32;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;

    localparam logic [COUNT_W-1:0]   COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              restart;
    } text_t;

    typedef struct packed {
        logic               match_found;
        logic [COUNT_W-1:0] match_count;
        logic [LEN_W-1:0]   matched_length;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD,
        ST_MATCH,
        ST_LINK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [IDX_W-1:0]  idx_a;
        logic [IDX_W-1:0]  idx_b;
        logic              use_text;
        logic [BYTE_W-1:0] text_byte;
    } cmp_req_t;

    typedef struct packed {
        logic             clear;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [LEN_W-1:0] wr_data;
        logic [IDX_W-1:0] rd_addr;
    } tbl_ctl_t;

endpackage

### hdl/kmp_failure_table.sv
// ----------------------------------------------------------------------------
// kmp_failure_table
// failure link storage with one write port, one read port and a full clear
// ----------------------------------------------------------------------------
module kmp_failure_table
    import kmp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  tbl_ctl_t         ctl,
    output logic [LEN_W-1:0] rd_data
);

    logic [LEN_W-1:0] link_reg [PATTERN_MAX];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < PATTERN_MAX; n++)
            begin
                link_reg[n] <= '0;
            end
        end
        else if (ctl.clear)
        begin
            for (int n = 0; n < PATTERN_MAX; n++)
            begin
                link_reg[n] <= '0;
            end
        end
        else if (ctl.wr_en)
        begin
            link_reg[ctl.wr_addr] <= ctl.wr_data;
        end
    end

    assign rd_data = link_reg[ctl.rd_addr];

endmodule

### hdl/kmp_byte_compare.sv
// ----------------------------------------------------------------------------
// kmp_byte_compare
// shared compare unit: pattern byte against pattern byte or text byte
// ----------------------------------------------------------------------------
module kmp_byte_compare
    import kmp_pkg::*;
(
    input  logic [PATTERN_MAX*BYTE_W-1:0] pattern,
    input  cmp_req_t                      req,
    output logic                          equal
);

    logic [BYTE_W-1:0] byte_a;
    logic [BYTE_W-1:0] byte_b;

    always_comb
    begin
        byte_a = pattern[req.idx_a * BYTE_W +: BYTE_W];
        byte_b = req.use_text ? req.text_byte : pattern[req.idx_b * BYTE_W +: BYTE_W];
        equal  = (byte_a == byte_b);
    end

endmodule

### hdl/kmp_stream_pattern_matcher.sv
// ----------------------------------------------------------------------------
// kmp_stream_pattern_matcher
// streaming knuth-morris-pratt matcher with a sequenced shared byte compare
// ----------------------------------------------------------------------------
// sequence: accept in ST_IDLE, compare steps in ST_MATCH (one plus failure
//   links followed), ST_LINK on a full occurrence, then ST_EMIT for the result
// ST_EMIT waits while a held result is stalled; a new text byte is taken only in
//   ST_IDLE, once the previous result is registered
// a write to the low, high or length register rebuilds the failure table
// reset: pattern of one zero byte, table and count zero, ready at once
module kmp_stream_pattern_matcher
    import kmp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 text_valid,
    output logic                 text_stall,
    input  text_t                text_data,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result_data,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   pat_low_reg, pat_low_next;
    logic [CFG_W-1:0]   pat_high_reg, pat_high_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   i_reg, i_next;
    logic [LEN_W-1:0]   k_reg, k_next;
    logic [LEN_W-1:0]   q_reg, q_next;
    logic [LEN_W-1:0]   walk_reg, walk_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0]  c_reg, c_next;
    logic               found_reg, found_next;
    logic [LEN_W-1:0]   rep_reg, rep_next;
    logic               result_valid_reg, result_valid_next;
    result_t            result_data_reg, result_data_next;

    logic [LEN_W-1:0]   m;
    logic [LEN_W-1:0]   walk_start;
    logic [LEN_W-1:0]   step_len;
    logic               equal;
    logic [LEN_W-1:0]   rd_data;
    cmp_req_t           cmp_req;
    tbl_ctl_t           tbl_ctl;

    kmp_failure_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (tbl_ctl),
        .rd_data (rd_data)
    );

    kmp_byte_compare u_compare (
        .pattern ({pat_high_reg, pat_low_reg}),
        .req     (cmp_req),
        .equal   (equal)
    );

    // active pattern length, clamped to one .. PATTERN_MAX
    always_comb
    begin
        if (len_reg == '0)
        begin
            m = LEN_W'(1);
        end
        else if (len_reg > LEN_W'(PATTERN_MAX))
        begin
            m = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            m = len_reg;
        end
    end

    assign text_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pat_low_reg      <= '0;
            pat_high_reg     <= '0;
            len_reg          <= LEN_W'(1);
            q_reg            <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pat_low_reg      <= pat_low_next;
            pat_high_reg     <= pat_high_next;
            len_reg          <= len_next;
            q_reg            <= q_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg           <= i_next;
        k_reg           <= k_next;
        walk_reg        <= walk_next;
        c_reg           <= c_next;
        found_reg       <= found_next;
        rep_reg         <= rep_next;
        result_data_reg <= result_data_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        pat_low_next      = pat_low_reg;
        pat_high_next     = pat_high_reg;
        len_next          = len_reg;
        i_next            = i_reg;
        k_next            = k_reg;
        q_next            = q_reg;
        walk_next         = walk_reg;
        count_next        = count_reg;
        c_next            = c_reg;
        found_next        = found_reg;
        rep_next          = rep_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_data_next  = result_data_reg;

        walk_start = text_data.restart ? '0 : q_reg;
        if (walk_start >= m)
        begin
            walk_start = '0;
        end
        step_len = '0;

        cmp_req.idx_a     = walk_reg[IDX_W-1:0];
        cmp_req.idx_b     = i_reg[IDX_W-1:0];
        cmp_req.use_text  = 1'b1;
        cmp_req.text_byte = c_reg;

        tbl_ctl.clear   = 1'b0;
        tbl_ctl.wr_en   = 1'b0;
        tbl_ctl.wr_addr = i_reg[IDX_W-1:0];
        tbl_ctl.wr_data = '0;
        tbl_ctl.rd_addr = IDX_W'(walk_reg - LEN_W'(1));

        case (state_reg)
            ST_IDLE:
            begin
                if (text_valid)
                begin
                    c_next    = text_data.text_byte;
                    walk_next = walk_start;
                    if (text_data.restart)
                    begin
                        count_next = '0;
                    end
                    state_next = ST_MATCH;
                end
            end
            ST_BUILD:
            begin
                cmp_req.idx_a    = k_reg[IDX_W-1:0];
                cmp_req.use_text = 1'b0;
                tbl_ctl.rd_addr  = IDX_W'(k_reg - LEN_W'(1));
                if (i_reg >= m)
                begin
                    state_next = ST_IDLE;
                end
                else if (k_reg != '0 && !equal)
                begin
                    k_next = rd_data;
                end
                else
                begin
                    step_len        = k_reg + LEN_W'(equal);
                    tbl_ctl.wr_en   = 1'b1;
                    tbl_ctl.wr_data = step_len;
                    k_next          = step_len;
                    i_next          = i_reg + LEN_W'(1);
                end
            end
            ST_MATCH:
            begin
                if (walk_reg != '0 && !equal)
                begin
                    walk_next = rd_data;
                end
                else
                begin
                    step_len = walk_reg + LEN_W'(equal);
                    rep_next = step_len;
                    if (step_len >= m)
                    begin
                        found_next = 1'b1;
                        if (count_reg != COUNT_MAX)
                        begin
                            count_next = count_reg + COUNT_W'(1);
                        end
                        state_next = ST_LINK;
                    end
                    else
                    begin
                        found_next = 1'b0;
                        q_next     = step_len;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_LINK:
            begin
                tbl_ctl.rd_addr = IDX_W'(m - LEN_W'(1));
                q_next          = rd_data;
                state_next      = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next               = 1'b1;
                    result_data_next.match_found    = found_reg;
                    result_data_next.match_count    = count_reg;
                    result_data_next.matched_length = rep_reg;
                    state_next                      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a write to the low, high or length register restarts the table build and drops the match state
        if (cfg_write && (cfg_index == CFG_PAT_LOW || cfg_index == CFG_PAT_HIGH
                          || cfg_index == CFG_PAT_LEN))
        begin
            case (cfg_index)
                CFG_PAT_LOW:  pat_low_next  = cfg_data;
                CFG_PAT_HIGH: pat_high_next = cfg_data;
                CFG_PAT_LEN:  len_next      = cfg_data[LEN_W-1:0];
                default:      len_next      = len_reg;
            endcase
            tbl_ctl.clear = 1'b1;
            tbl_ctl.wr_en = 1'b0;
            i_next        = LEN_W'(1);
            k_next        = '0;
            q_next        = '0;
            state_next    = ST_BUILD;
        end
    end

    a_accept_starts_match: assert property (@(posedge clk) disable iff (!rst_n)
        (text_valid && !text_stall && !cfg_write) |=> (state_reg == ST_MATCH))
        else $error("accepted transaction did not start the match walk");

    a_idle_state_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (q_reg < m))
        else $error("stored match length not below pattern length");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MATCH) |-> (walk_reg < m))
        else $error("match walk left the pattern");

    a_build_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUILD) |-> (k_reg < i_reg))
        else $error("failure table build lost prefix order");

endmodule
